@@ rtl/ascii85_stream_encoder_defines.svh @@
// Assertion macros for the ASCII85 stream encoder.
// With SYNTHESIS defined, every macro expands to nothing.
`ifndef ASCII85_STREAM_ENCODER_DEFINES_SVH
`define ASCII85_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define A85_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("a85 same-cycle check failed");

// Next-cycle implication.
`define A85_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("a85 next-cycle check failed");

`else

`define A85_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define A85_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

@@ rtl/a85_pkg.sv @@
package a85_pkg;

  // Encoding constants
  localparam logic [6:0] A85_OFFSET = 7'd33;
  localparam logic [6:0] A85_Z_CHAR = 7'd122;
  localparam logic [6:0] A85_MAX_DIGIT_CHAR = 7'd117;

  // Reciprocal of 85 for 32-bit dividends: q = (v * A85_RECIP) >> A85_RECIP_SHIFT
  localparam logic [31:0] A85_RECIP = 32'hC0C0C0C1;
  localparam int A85_RECIP_SHIFT = 38;
  localparam int A85_QUOT_W = 26;

  localparam int A85_DIGITS = 5;

  // One group to encode, handed from the front to the back
  typedef struct packed {
    logic [31:0] value;   // zero padded group, big endian
    logic [2:0]  ndig;    // characters to emit, 2..5
    logic        zero;    // full zero group: emit a single 'z'
  } a85_job_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } a85_qstat_t;

endpackage

@@ rtl/ascii85_stream_encoder.sv @@
// Channel   Handshake         Payload
// input     push / full       data_byte[7:0], final_byte
// result    empty / pop       out_char[6:0], run_end
//
// A byte is classified in its transfer cycle; a byte that completes or ends a
// group queues one job. The back unit divides a non-zero job by 85 five times
// (reciprocal multiply, then remainder); a zero group skips it. The emitter
// sends one character per cycle while pop keeps up, from its own buffer while
// the next group divides. Reset (rst, synchronous) empties the queue, the held
// group and the output register. full follows the job queue only.
`include "ascii85_stream_encoder_defines.svh"

module ascii85_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       run_end
);
  import a85_pkg::*;

  a85_job_t   wr_job;
  a85_job_t   rd_job;
  a85_qstat_t qstat;
  logic       job_wr;
  logic       job_rd;

  // Front: group assembly and classification
  a85_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .qstat      (qstat),
    .job_wr     (job_wr),
    .job        (wr_job)
  );

  // Job queue between the two sides
  a85_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_wr),
    .wr_job (wr_job),
    .rd     (job_rd),
    .rd_job (rd_job),
    .qstat  (qstat)
  );

  // Back: digit generation and character output
  a85_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (rd_job),
    .qstat    (qstat),
    .job_rd   (job_rd),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .run_end  (run_end)
  );

  // Checks
  `A85_ASSERT_IMPLY(a_no_write_when_full, clk, rst, job_wr, !qstat.full)
  `A85_ASSERT_IMPLY(a_char_range, clk, rst, !empty, (out_char >= A85_OFFSET) &&
    ((out_char <= A85_MAX_DIGIT_CHAR) || (out_char == A85_Z_CHAR)))
  `A85_ASSERT_IMPLY(a_z_ends_run, clk, rst, !empty && (out_char == A85_Z_CHAR), run_end)
  `A85_ASSERT_NEXT(a_queue_has_job, clk, rst, job_wr && qstat.empty && !job_rd, !qstat.empty)

endmodule

@@ rtl/a85_front.sv @@
module a85_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  input  a85_pkg::a85_qstat_t qstat,
  output logic              job_wr,
  output a85_pkg::a85_job_t job
);
  import a85_pkg::*;

  logic [23:0] group_bytes;
  logic [1:0]  bytes_held;
  logic        take;
  logic [31:0] padded;

  assign full = qstat.full;
  assign take = push && !qstat.full;

  // Zero-padded value of the partial group ending with this byte
  always_comb begin
    case (bytes_held)
      2'd0:    padded = {data_byte, 24'h000000};
      2'd1:    padded = {group_bytes[7:0], data_byte, 16'h0000};
      2'd2:    padded = {group_bytes[15:0], data_byte, 8'h00};
      default: padded = {group_bytes, data_byte};
    endcase
  end

  // Classify the byte: full group, flushed partial group, or held
  always_comb begin
    job.value = padded;
    if (bytes_held == 2'd3) begin
      job.ndig = 3'd5;
      job.zero = (padded == 32'h0);
    end else begin
      job.ndig = {1'b0, bytes_held} + 3'd2;
      job.zero = 1'b0;
    end
    job_wr = take && ((bytes_held == 2'd3) || final_byte);
  end

  // Group assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes <= '0;
      bytes_held  <= '0;
    end else if (take) begin
      if ((bytes_held == 2'd3) || final_byte) begin
        group_bytes <= '0;
        bytes_held  <= '0;
      end else begin
        group_bytes <= {group_bytes[15:0], data_byte};
        bytes_held  <= bytes_held + 2'd1;
      end
    end
  end

endmodule

@@ rtl/a85_fifo.sv @@
module a85_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  a85_pkg::a85_job_t   wr_job,
  input  logic                rd,
  output a85_pkg::a85_job_t   rd_job,
  output a85_pkg::a85_qstat_t qstat
);
  import a85_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  a85_job_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign qstat.full  = (count == FULL_COUNT);
  assign qstat.empty = (count == '0);
  assign do_wr = wr && !qstat.full;
  assign do_rd = rd && !qstat.empty;
  assign rd_job = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/a85_back.sv @@
module a85_back (
  input  logic                clk,
  input  logic                rst,
  input  a85_pkg::a85_job_t   job,
  input  a85_pkg::a85_qstat_t qstat,
  output logic                job_rd,
  input  logic                pop,
  output logic                empty,
  output logic [6:0]          out_char,
  output logic                run_end
);
  import a85_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_SUB  = 2'd2;
  localparam logic [1:0] D_DONE = 2'd3;

  // Divider state
  logic [1:0]            dstate;
  logic [31:0]           value;
  logic [A85_QUOT_W-1:0] quot;
  logic [2:0]            step;
  logic [2:0]            ndig;
  logic [6:0]            dig [A85_DIGITS];

  // Emitter state
  logic [6:0]            ebuf [A85_DIGITS];
  logic [2:0]            remain;
  logic                  out_valid;

  logic [63:0]           product;
  logic [6:0]            q_lo;
  logic [6:0]            q85_lo;
  logic [6:0]            rem_lo;
  logic                  handoff;
  logic                  emit;

  assign job_rd  = (dstate == D_IDLE) && !qstat.empty;
  assign handoff = (dstate == D_DONE) && (remain == 3'd0);
  assign emit    = (remain != 3'd0) && (!out_valid || pop);
  assign empty   = !out_valid;

  // Quotient by reciprocal, remainder from the low bits only (it is below 85)
  assign product = {32'h0, value} * {32'h0, A85_RECIP};
  assign q_lo    = quot[6:0];
  assign q85_lo  = 7'({q_lo, 6'b0}) + 7'({q_lo, 4'b0}) + 7'({q_lo, 2'b0}) + q_lo;
  assign rem_lo  = value[6:0] - q85_lo;

  // Divider sequencer: five divide-by-85 steps (multiply, then remainder), LSB digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      step   <= '0;
    end else begin
      case (dstate)
        D_IDLE: begin
          if (job_rd) begin
            step <= '0;
            dstate <= job.zero ? D_DONE : D_MUL;
          end
        end
        D_MUL: begin
          dstate <= D_SUB;
        end
        D_SUB: begin
          if (step == 3'(A85_DIGITS - 1)) begin
            dstate <= D_DONE;
          end else begin
            step   <= step + 3'd1;
            dstate <= D_MUL;
          end
        end
        default: begin
          if (handoff) begin
            dstate <= D_IDLE;
          end
        end
      endcase
    end
  end

  // Divider datapath; each new digit enters at the head, so the most
  // significant one ends up in slot 0
  always_ff @(posedge clk) begin
    case (dstate)
      D_IDLE: begin
        if (job_rd) begin
          value <= job.value;
          ndig  <= job.zero ? 3'd1 : job.ndig;
          if (job.zero) begin
            dig[0] <= A85_Z_CHAR;
          end
        end
      end
      D_MUL: begin
        quot <= product[A85_RECIP_SHIFT +: A85_QUOT_W];
      end
      D_SUB: begin
        value <= {{(32 - A85_QUOT_W){1'b0}}, quot};
        for (int k = 0; k < A85_DIGITS - 1; k++) begin
          dig[k+1] <= dig[k];
        end
        dig[0] <= rem_lo + A85_OFFSET;
      end
      default: begin
      end
    endcase
  end

  // Emitter buffer: most significant character at the head
  always_ff @(posedge clk) begin
    if (handoff) begin
      ebuf <= dig;
    end else if (emit) begin
      for (int k = 0; k < A85_DIGITS - 1; k++) begin
        ebuf[k] <= ebuf[k+1];
      end
    end
  end

  // Emitter control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (handoff) begin
        remain <= ndig;
      end else if (emit) begin
        remain <= remain - 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= ebuf[0];
      run_end  <= (remain == 3'd1);
    end
  end

endmodule

@@ verif/ascii85_stream_encoder_tb.sv @@
`timescale 1ns / 1ps

module ascii85_stream_encoder_tb;
  import a85_pkg::*;

  localparam int GAP_MAX      = 14;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int TARGET_BYTES = 460;
  localparam int REPORT_MAX   = 10;
  localparam int BASE         = 85;

  // One expected output character
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } a85_char_t;

  // Tracks the group being packed and the characters still owed by the block
  class a85_scoreboard;
    logic [23:0] group_acc;
    logic [1:0]  held;
    a85_char_t   pending_chars[$];
    int          mismatches;
    int          chars_checked;
    int          zero_groups;

    function new();
      group_acc     = '0;
      held          = '0;
      mismatches    = 0;
      chars_checked = 0;
      zero_groups   = 0;
    endfunction

    // Base-85 digits of a padded group, most significant first
    function void queue_digits(logic [31:0] word, int count);
      logic [6:0] digit [5];
      logic [31:0] rest;
      a85_char_t c;
      int k;
      rest = word;
      for (k = 4; k >= 0; k--) begin
        digit[k] = 7'(rest % BASE);
        rest = rest / BASE;
      end
      for (k = 0; k < count; k++) begin
        c.ch   = digit[k] + A85_OFFSET;
        c.last = (k == count - 1);
        pending_chars.push_back(c);
      end
    endfunction

    // Called on every accepted input transfer
    function void note_byte(logic [7:0] b, logic fin);
      logic [31:0] word;
      a85_char_t c;
      int nbytes;
      if (held == 2'd3) begin
        // fourth byte completes the group; final flag changes nothing here
        word      = {group_acc, b};
        group_acc = '0;
        held      = '0;
        if (word == '0) begin
          c.ch   = A85_Z_CHAR;
          c.last = 1'b1;
          pending_chars.push_back(c);
          zero_groups++;
        end else begin
          queue_digits(word, 5);
        end
      end else begin
        group_acc = {group_acc[15:0], b};
        held      = held + 2'd1;
        if (fin) begin
          // partial group: zero pad, n+1 digits, never 'z'
          nbytes    = held;
          word      = {group_acc, 8'h00} << (8 * (3 - nbytes));
          group_acc = '0;
          held      = '0;
          queue_digits(word, nbytes + 1);
        end
      end
    endfunction

    // Called on every accepted result transfer
    function void check_char(logic [6:0] ch, logic last);
      a85_char_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: unexpected char %0d run_end %0b", ch, last);
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (want.ch !== ch || want.last !== last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR: char %0d: expected out_char %0d run_end %0b, got %0d %0b",
                   chars_checked, want.ch, want.last, ch, last);
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       push       = 1'b0;
  logic [7:0] data_byte  = 8'h00;
  logic       final_byte = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic [6:0] out_char;
  logic       run_end;

  a85_scoreboard board;

  int  bytes_sent    = 0;
  int  streams_sent  = 0;
  int  full_stalls   = 0;
  int  send_calm     = 0;
  int  recv_calm     = 0;
  int  burst_left    = 0;
  bit  hold_req      = 1'b0;
  bit  pressure_done = 1'b0;

  ascii85_stream_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .empty      (empty),
    .pop        (pop),
    .out_char   (out_char),
    .run_end    (run_end)
  );

  always #1 clk = ~clk;

  // Offer one byte after a random gap; returns once the transfer happened
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = $urandom_range(0, GAP_MAX);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else if ($urandom_range(0, 15) == 0) begin
      send_calm = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (full !== 1'b0) begin
      full_stalls++;
      @(posedge clk);
    end
    board.note_byte(b, fin);
    bytes_sent++;
  endtask

  // One stream of random length; the last byte carries the final flag
  task automatic send_stream(input int len);
    int mode;
    int i;
    logic [7:0] b;
    mode = $urandom_range(0, 9);
    for (i = 0; i < len; i++) begin
      if (mode < 6)
        b = 8'($urandom_range(0, 255));
      else if (mode < 8)
        b = 8'h00;
      else
        b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      send_byte(b, i == len - 1);
    end
    streams_sent++;
  endtask

  // Result side: random pop gaps, one long hold-off on request
  task automatic receive_chars();
    int gap;
    forever begin
      gap = $urandom_range(0, GAP_MAX);
      if (recv_calm > 0) begin
        gap = 0;
        recv_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        recv_calm = $urandom_range(8, 30);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty !== 1'b0) @(posedge clk);
      board.check_char(out_char, run_end);
    end
  endtask

  // Watchdog: ends the run when no transfer happens for too long
  initial begin
    int idle;
    idle = 0;
    wait (rst == 1'b0);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0))
        idle = 0;
      else
        idle++;
    end
    $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin
    int len;
    int directed;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      receive_chars();
    join_none

    // zero group, then all-ones group, both mid-stream
    repeat (4) send_byte(8'h00, 1'b0);
    repeat (4) send_byte(8'hff, 1'b0);
    // single-byte streams: zero pads to digits, not 'z'
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // two- and three-byte partial groups
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // final on the fourth byte: full group rules apply
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    repeat (3) send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b1);
    directed = bytes_sent;

    // random streams, with one burst against a stalled receiver
    while (bytes_sent < TARGET_BYTES) begin
      if (!pressure_done && bytes_sent >= 200) begin
        pressure_done = 1'b1;
        hold_req      = 1'b1;
        burst_left    = 48;
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      send_stream(len);
    end
    push <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes (%0d directed) in %0d random streams, input stalled %0d cycles",
             bytes_sent, directed, streams_sent, full_stalls);
    $display("Checked %0d characters, %0d zero groups, %0d mismatches, %0d still owed",
             board.chars_checked, board.zero_groups, board.mismatches,
             board.pending_chars.size());
    if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
